// ===== rtl/mbc_pkg.sv =====
// Shared types, codes and the CRC-16 byte update for the coil master.
// No dependencies; mbc_core, mbc_emit and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mbc_pkg;

    // Input command codes
    localparam logic [2:0] CMD_WR_SINGLE = 3'd0;
    localparam logic [2:0] CMD_WR_MULTI  = 3'd1;
    localparam logic [2:0] CMD_RD_COILS  = 3'd2;
    localparam logic [2:0] CMD_RX_BYTE   = 3'd3;
    localparam logic [2:0] CMD_TICK      = 3'd4;

    // Request kind as held while waiting for the reply
    localparam logic [1:0] REQ_RD = 2'd2;

    // Completion status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TIMEOUT = 3'd1;
    localparam logic [2:0] ST_FRAME   = 3'd2;
    localparam logic [2:0] ST_CRC     = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    // Result kinds
    localparam logic OUT_TX   = 1'b0;
    localparam logic OUT_DONE = 1'b1;

    // Function codes and frame constants
    localparam logic [7:0]  FC_WR_SINGLE = 8'h05;
    localparam logic [7:0]  FC_WR_MULTI  = 8'h0F;
    localparam logic [7:0]  FC_RD_COILS  = 8'h01;
    localparam logic [7:0]  COIL_ON      = 8'hFF;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [15:0] TIMEOUT_RST  = 16'd1000;
    localparam logic [3:0]  RPL_LEN_WR   = 4'd8;
    localparam logic [3:0]  RPL_BASE_RD  = 4'd5;
    localparam logic [3:0]  FRM_BASE     = 4'd6;
    localparam logic [3:0]  FRM_BASE_WM  = 4'd7;

    localparam int FRM_MAX = 9;  // data bytes of the longest frame, CRC excluded
    localparam int HDR_LEN = 6;

    typedef logic [7:0] t_byte;

    // One batch of results handed from the core to the emitter
    typedef struct packed {
        logic                       kind;
        logic [2:0]                 status;
        logic [15:0]                value;
        logic [3:0]                 dlen;
        logic [FRM_MAX-1:0][7:0]    frm;
    } t_emit;

    // One byte through the reflected CRC-16 (poly 0xA001)
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mbc_in_if.sv =====
// Request channel: command plus request or reply-byte payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface mbc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  dev_addr;
    logic [15:0] coil_addr;
    logic [15:0] coil_count;
    logic [15:0] coil_value;
    logic [7:0]  rx_byte;

    modport source (output valid, cmd, dev_addr, coil_addr, coil_count, coil_value,
                    rx_byte, input ready);
    modport sink (input valid, cmd, dev_addr, coil_addr, coil_count, coil_value,
                  rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/mbc_out_if.sv =====
// Result channel: transmit bytes and completions.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface mbc_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic [2:0]  status;
    logic [15:0] read_value;
    logic        last;

    modport source (output valid, kind, tx_byte, status, read_value, last, input ready);
    modport sink (input valid, kind, tx_byte, status, read_value, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/mbc_cfg_if.sv =====
// Configuration write channel: the reply timeout in milliseconds.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface mbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mbc_core.sv =====
// Input register and transaction state: builds request frames, collects
// and checks reply bytes, runs the timeout. Uses mbc_pkg, mbc_in_if, mbc_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module mbc_core #(
    parameter int MAX_COILS = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    mbc_in_if.sink          i_req,
    mbc_cfg_if.sink         i_cfg,
    input  wire             i_can_load,
    output logic            o_load,
    output mbc_pkg::t_emit  o_emit
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;

    // Input register
    logic        r_in_valid;
    logic [2:0]  r_in_cmd;
    logic [7:0]  r_in_slave;
    logic [15:0] r_in_caddr;
    logic [15:0] r_in_count;
    logic [15:0] r_in_value;
    logic [7:0]  r_in_rx;

    // Transaction state
    logic [1:0]  r_phase,   n_phase;
    logic [1:0]  r_kind,    n_kind;
    logic [3:0]  r_exp,     n_exp;
    logic [3:0]  r_rcv,     n_rcv;
    logic [15:0] r_crc,     n_crc;
    logic [15:0] r_elapsed, n_elapsed;
    logic [15:0] r_timeout;
    mbc_pkg::t_byte r_hdr   [0:mbc_pkg::HDR_LEN-1];
    mbc_pkg::t_byte r_reply [0:mbc_pkg::HDR_LEN-1];
    mbc_pkg::t_byte r_prev;

    logic        w_adv;
    logic        w_has;
    logic        w_hdr_we;
    logic        w_rpl_we;
    logic        w_over;
    logic [4:0]  w_nb_sum;
    logic [1:0]  w_nb;
    logic [3:0]  w_dlen;
    logic [3:0]  w_exp;
    logic [mbc_pkg::FRM_MAX-1:0][7:0] w_frm;
    mbc_pkg::t_byte w_rb [0:mbc_pkg::HDR_LEN-1];
    logic        w_hdr_bad;
    logic        w_crc_bad;
    logic [2:0]  w_fin_status;
    logic [15:0] w_fin_value;
    mbc_pkg::t_emit w_emit;

    assign w_adv       = r_in_valid && (!w_has || i_can_load);
    assign i_req.ready = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;
    assign o_load      = w_adv && w_has;
    assign o_emit      = w_emit;

    // Request frame, CRC excluded; the emitter appends it on the way out
    assign w_over   = r_in_count > 16'(MAX_COILS);
    assign w_nb_sum = r_in_count[4:0] + 5'd7;
    assign w_nb     = w_nb_sum[4:3];
    assign w_dlen   = (r_in_cmd == mbc_pkg::CMD_WR_MULTI)
                      ? (mbc_pkg::FRM_BASE_WM + {2'b00, w_nb}) : mbc_pkg::FRM_BASE;
    assign w_exp    = (r_in_cmd == mbc_pkg::CMD_RD_COILS)
                      ? (mbc_pkg::RPL_BASE_RD + {2'b00, w_nb}) : mbc_pkg::RPL_LEN_WR;

    always_comb begin
        w_frm    = '0;
        w_frm[0] = r_in_slave;
        w_frm[2] = r_in_caddr[15:8];
        w_frm[3] = r_in_caddr[7:0];
        case (r_in_cmd)
            mbc_pkg::CMD_WR_SINGLE: begin
                w_frm[1] = mbc_pkg::FC_WR_SINGLE;
                w_frm[4] = r_in_value[0] ? mbc_pkg::COIL_ON : 8'h00;
            end
            mbc_pkg::CMD_WR_MULTI: begin
                w_frm[1] = mbc_pkg::FC_WR_MULTI;
                w_frm[4] = r_in_count[15:8];
                w_frm[5] = r_in_count[7:0];
                w_frm[6] = {6'b000000, w_nb};
                if (w_nb == 2'd1) begin
                    w_frm[7] = r_in_value[7:0];
                end else if (w_nb == 2'd2) begin
                    w_frm[7] = r_in_value[15:8];
                    w_frm[8] = r_in_value[7:0];
                end
            end
            default: begin
                w_frm[1] = mbc_pkg::FC_RD_COILS;
                w_frm[4] = r_in_count[15:8];
                w_frm[5] = r_in_count[7:0];
            end
        endcase
    end

    // Reply bytes as they stand once the current byte is stored
    always_comb begin
        for (int i = 0; i < mbc_pkg::HDR_LEN; i++) begin
            w_rb[i] = (r_rcv == 4'(i)) ? r_in_rx : r_reply[i];
        end
    end

    // Header echo first, then the CRC held in the last two bytes
    always_comb begin
        w_hdr_bad = (w_rb[0] != r_hdr[0]) || (w_rb[1] != r_hdr[1]);
        if (r_kind != mbc_pkg::REQ_RD) begin
            w_hdr_bad = w_hdr_bad || (w_rb[2] != r_hdr[2]) || (w_rb[3] != r_hdr[3])
                        || (w_rb[4] != r_hdr[4]) || (w_rb[5] != r_hdr[5]);
        end
        w_crc_bad   = {r_prev, r_in_rx} != r_crc;
        w_fin_value = '0;
        if (w_hdr_bad) begin
            w_fin_status = mbc_pkg::ST_FRAME;
        end else if (w_crc_bad) begin
            w_fin_status = mbc_pkg::ST_CRC;
        end else begin
            w_fin_status = mbc_pkg::ST_OK;
            if (r_kind == mbc_pkg::REQ_RD) begin
                if (w_rb[2] == 8'd1) begin
                    w_fin_value = {8'h00, w_rb[3]};
                end else if (w_rb[2] == 8'd2) begin
                    w_fin_value = {w_rb[3], w_rb[4]};
                end
            end
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_exp     = r_exp;
        n_rcv     = r_rcv;
        n_crc     = r_crc;
        n_elapsed = r_elapsed;
        w_has     = 1'b0;
        w_hdr_we  = 1'b0;
        w_rpl_we  = 1'b0;
        w_emit    = '0;
        case (r_in_cmd)
            mbc_pkg::CMD_WR_SINGLE, mbc_pkg::CMD_WR_MULTI, mbc_pkg::CMD_RD_COILS: begin
                if (r_phase == PH_IDLE) begin
                    w_has = 1'b1;
                    if (r_in_cmd != mbc_pkg::CMD_WR_SINGLE && w_over) begin
                        w_emit.kind   = mbc_pkg::OUT_DONE;
                        w_emit.status = mbc_pkg::ST_RANGE;
                    end else begin
                        w_emit.kind = mbc_pkg::OUT_TX;
                        w_emit.frm  = w_frm;
                        w_emit.dlen = w_dlen;
                        w_hdr_we    = 1'b1;
                        n_kind      = r_in_cmd[1:0];
                        n_exp       = w_exp;
                        n_rcv       = '0;
                        n_crc       = mbc_pkg::CRC_INIT;
                        n_elapsed   = '0;
                        n_phase     = PH_WAIT;
                    end
                end
            end
            mbc_pkg::CMD_RX_BYTE: begin
                if (r_phase == PH_WAIT) begin
                    w_rpl_we = r_rcv < 4'(mbc_pkg::HDR_LEN);
                    n_rcv    = r_rcv + 4'd1;
                    // trailer bytes stay out of the running CRC
                    if ({1'b0, r_rcv} + 5'd2 < {1'b0, r_exp}) begin
                        n_crc = mbc_pkg::crc_feed(r_crc, r_in_rx);
                    end
                    if (n_rcv >= r_exp) begin
                        w_has         = 1'b1;
                        w_emit.kind   = mbc_pkg::OUT_DONE;
                        w_emit.status = w_fin_status;
                        w_emit.value  = w_fin_value;
                        n_phase       = PH_IDLE;
                    end
                end
            end
            mbc_pkg::CMD_TICK: begin
                if (r_phase == PH_WAIT) begin
                    if (r_elapsed >= r_timeout) begin
                        w_has         = 1'b1;
                        w_emit.kind   = mbc_pkg::OUT_DONE;
                        w_emit.status = mbc_pkg::ST_TIMEOUT;
                        n_phase       = PH_IDLE;
                    end else begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_kind     <= '0;
            r_exp      <= '0;
            r_rcv      <= '0;
            r_crc      <= mbc_pkg::CRC_INIT;
            r_elapsed  <= '0;
            r_timeout  <= mbc_pkg::TIMEOUT_RST;
        end else begin
            if (i_cfg.valid) begin
                r_timeout <= i_cfg.data;
            end
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_phase   <= n_phase;
                r_kind    <= n_kind;
                r_exp     <= n_exp;
                r_rcv     <= n_rcv;
                r_crc     <= n_crc;
                r_elapsed <= n_elapsed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_cmd   <= i_req.cmd;
            r_in_slave <= i_req.dev_addr;
            r_in_caddr <= i_req.coil_addr;
            r_in_count <= i_req.coil_count;
            r_in_value <= i_req.coil_value;
            r_in_rx    <= i_req.rx_byte;
        end
        if (w_adv && w_hdr_we) begin
            for (int i = 0; i < mbc_pkg::HDR_LEN; i++) begin
                r_hdr[i] <= w_frm[i];
            end
        end
        if (w_adv && w_rpl_we) begin
            r_reply[r_rcv[2:0]] <= r_in_rx;
        end
        if (w_adv && r_in_cmd == mbc_pkg::CMD_RX_BYTE && r_phase == PH_WAIT) begin
            r_prev <= r_in_rx;
        end
    end

    // While waiting, the reply is never complete
    a_rcv_below_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_WAIT |-> r_rcv < r_exp)
        else $error("reply count reached expected length while waiting");

    // A completion always returns the block to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load && w_emit.kind == mbc_pkg::OUT_DONE |=> r_phase == PH_IDLE)
        else $error("completion left a transaction open");

    // A frame is only sent when a reply wait starts
    a_tx_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load && w_emit.kind == mbc_pkg::OUT_TX |=> r_phase == PH_WAIT && r_rcv == 4'd0)
        else $error("frame sent without entering the reply wait");

endmodule

`default_nettype wire

// ===== rtl/mbc_emit.sv =====
// Result register: shifts out frame bytes with the CRC trailer, or holds
// one completion. Uses mbc_pkg and mbc_out_if.
`timescale 1ns / 1ps
`default_nettype none

module mbc_emit (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_load,
    input  mbc_pkg::t_emit  i_emit,
    output logic            o_can_load,
    mbc_out_if.source       o_rsp
);

    logic        r_busy;
    logic        r_kind;
    logic [2:0]  r_status;
    logic [15:0] r_value;
    logic [mbc_pkg::FRM_MAX-1:0][7:0] r_frm;
    logic [3:0]  r_dcnt;
    logic [1:0]  r_tcnt;
    logic [15:0] r_crc;

    logic        w_fire;
    logic        w_last;
    logic        w_done;
    logic [7:0]  w_byte;

    assign w_last = (r_kind == mbc_pkg::OUT_TX) && (r_dcnt == 4'd0) && (r_tcnt == 2'd1);
    assign w_fire = r_busy && o_rsp.ready;
    assign w_done = w_fire && ((r_kind == mbc_pkg::OUT_DONE) || w_last);
    assign o_can_load = !r_busy || w_done;

    always_comb begin
        if (r_kind == mbc_pkg::OUT_DONE) begin
            w_byte = 8'h00;
        end else if (r_dcnt != 4'd0) begin
            w_byte = r_frm[0];
        end else if (r_tcnt == 2'd2) begin
            w_byte = r_crc[15:8];
        end else begin
            w_byte = r_crc[7:0];
        end
    end

    assign o_rsp.valid      = r_busy;
    assign o_rsp.kind       = r_kind;
    assign o_rsp.tx_byte    = w_byte;
    assign o_rsp.status     = r_status;
    assign o_rsp.read_value = r_value;
    assign o_rsp.last       = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_kind <= mbc_pkg::OUT_TX;
            r_dcnt <= '0;
            r_tcnt <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_kind <= i_emit.kind;
            if (i_emit.kind == mbc_pkg::OUT_DONE) begin
                r_dcnt <= '0;
                r_tcnt <= '0;
            end else begin
                r_dcnt <= i_emit.dlen;
                r_tcnt <= 2'd2;
            end
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (w_fire) begin
            if (r_dcnt != 4'd0) begin
                r_dcnt <= r_dcnt - 4'd1;
            end else begin
                r_tcnt <= r_tcnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= i_emit.status;
            r_value  <= i_emit.value;
            r_frm    <= i_emit.frm;
            r_crc    <= mbc_pkg::CRC_INIT;
        end else if (w_fire && r_dcnt != 4'd0) begin
            // advance the frame, fold the departing byte into the trailer
            r_frm <= {8'h00, r_frm[mbc_pkg::FRM_MAX-1:1]};
            r_crc <= mbc_pkg::crc_feed(r_crc, r_frm[0]);
        end
    end

    // A stalled result keeps its position in the frame
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !o_rsp.ready |=> r_busy && $stable(r_dcnt) && $stable(r_tcnt))
        else $error("result moved while the receiver stalled");

    // Completions carry no frame byte and no end marker
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_kind == mbc_pkg::OUT_DONE |-> w_byte == 8'h00 && !w_last)
        else $error("completion carries frame fields");

    // A frame never loads with fewer data bytes than the fixed header
    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && i_emit.kind == mbc_pkg::OUT_TX |=> r_dcnt >= 4'd6 && r_dcnt <= 4'd9)
        else $error("frame length out of range");

endmodule

`default_nettype wire

// ===== rtl/modbus_rtu_coil_master.sv =====
// Modbus RTU coil master: request frames with CRC trailer, reply checking
// and timeout. Top level; uses mbc_pkg, the channel interfaces, mbc_core, mbc_emit.
//
// Usage:
//   i_req carries commands: write single coil, write multiple coils, read
//   coils, one received reply byte, or a millisecond tick. o_rsp carries
//   results: frame bytes to transmit (last marks the final CRC byte) and
//   one completion per transaction with status and read data. i_cfg writes
//   the reply timeout in milliseconds; it is always ready.
//   An accepted item is held in the input register, and its first result
//   is registered in the result register before it reaches o_rsp. A request
//   frame of N bytes leaves at one byte per cycle while the receiver is
//   ready, from the result register; the trailer CRC is folded in as the
//   data bytes go out. Items with no result (bytes, ticks) pass at one per
//   cycle; an item with results waits in the input register until the result
//   register has delivered its previous frame or completion.
//   Reset leaves the block idle with a timeout of 1000 ms. When the
//   receiver stalls, the current result holds; items without results keep
//   passing until one with results reaches the input register, then
//   i_req.ready drops until results move again.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_coil_master #(
    parameter int MAX_COILS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mbc_in_if.sink     i_req,
    mbc_cfg_if.sink    i_cfg,
    mbc_out_if.source  o_rsp
);

    logic           w_load;
    logic           w_can_load;
    mbc_pkg::t_emit w_emit;

    mbc_core #(
        .MAX_COILS (MAX_COILS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg      (i_cfg),
        .i_can_load (w_can_load),
        .o_load     (w_load),
        .o_emit     (w_emit)
    );

    mbc_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_emit     (w_emit),
        .o_can_load (w_can_load),
        .o_rsp      (o_rsp)
    );

endmodule

`default_nettype wire
